### hdl/stk_pkg.sv
// Shared codes and helper functions for the stack machine execute unit.
`default_nettype none
package stk_pkg;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_SETPC = 2'd1;
  localparam logic [1:0] MODE_EXEC  = 2'd2;

  localparam logic [2:0] ST_DONE   = 3'd0;
  localparam logic [2:0] ST_PRINT  = 3'd1;
  localparam logic [2:0] ST_PRINTC = 3'd2;
  localparam logic [2:0] ST_HALTED = 3'd3;
  localparam logic [2:0] ST_BKPT   = 3'd4;
  localparam logic [2:0] ST_ERROR  = 3'd5;

  localparam logic [3:0] ERR_NONE   = 4'd0;
  localparam logic [3:0] ERR_DIV0   = 4'd1;
  localparam logic [3:0] ERR_ADDR   = 4'd2;
  localparam logic [3:0] ERR_SP     = 4'd3;
  localparam logic [3:0] ERR_DUMP   = 4'd4;
  localparam logic [3:0] ERR_PC     = 4'd5;
  localparam logic [3:0] ERR_OPC    = 4'd6;
  localparam logic [3:0] ERR_EOF    = 4'd7;
  localparam logic [3:0] ERR_BADINT = 4'd8;

  localparam int unsigned OPCODE_COUNT = 45;

  localparam logic [5:0] OP_BKPT   = 6'd0;
  localparam logic [5:0] OP_PUSH   = 6'd1;
  localparam logic [5:0] OP_PUSHC  = 6'd2;
  localparam logic [5:0] OP_PUSHI  = 6'd3;
  localparam logic [5:0] OP_PUSHX  = 6'd4;
  localparam logic [5:0] OP_POP    = 6'd5;
  localparam logic [5:0] OP_POPI   = 6'd6;
  localparam logic [5:0] OP_POPX   = 6'd7;
  localparam logic [5:0] OP_DUP    = 6'd8;
  localparam logic [5:0] OP_SWAP   = 6'd9;
  localparam logic [5:0] OP_OVER   = 6'd10;
  localparam logic [5:0] OP_DROP   = 6'd11;
  localparam logic [5:0] OP_ROT    = 6'd12;
  localparam logic [5:0] OP_TSTLT  = 6'd13;
  localparam logic [5:0] OP_TSTLE  = 6'd14;
  localparam logic [5:0] OP_TSTGT  = 6'd15;
  localparam logic [5:0] OP_TSTGE  = 6'd16;
  localparam logic [5:0] OP_TSTEQ  = 6'd17;
  localparam logic [5:0] OP_TSTNE  = 6'd18;
  localparam logic [5:0] OP_BNE    = 6'd19;
  localparam logic [5:0] OP_BEQ    = 6'd20;
  localparam logic [5:0] OP_BR     = 6'd21;
  localparam logic [5:0] OP_CALL   = 6'd22;
  localparam logic [5:0] OP_CALLS  = 6'd23;
  localparam logic [5:0] OP_RETURN = 6'd24;
  localparam logic [5:0] OP_HALT   = 6'd25;
  localparam logic [5:0] OP_ADD    = 6'd26;
  localparam logic [5:0] OP_SUB    = 6'd27;
  localparam logic [5:0] OP_MUL    = 6'd28;
  localparam logic [5:0] OP_DIV    = 6'd29;
  localparam logic [5:0] OP_MOD    = 6'd30;
  localparam logic [5:0] OP_OR     = 6'd31;
  localparam logic [5:0] OP_AND    = 6'd32;
  localparam logic [5:0] OP_XOR    = 6'd33;
  localparam logic [5:0] OP_NOT    = 6'd34;
  localparam logic [5:0] OP_NEG    = 6'd35;
  localparam logic [5:0] OP_ADDX   = 6'd36;
  localparam logic [5:0] OP_ADDSP  = 6'd37;
  localparam logic [5:0] OP_READ   = 6'd38;
  localparam logic [5:0] OP_PRINT  = 6'd39;
  localparam logic [5:0] OP_READC  = 6'd40;
  localparam logic [5:0] OP_PRINTC = 6'd41;
  localparam logic [5:0] OP_TRON   = 6'd42;
  localparam logic [5:0] OP_TROFF  = 6'd43;
  localparam logic [5:0] OP_DUMP   = 6'd44;

  function automatic logic has_arg(input logic [5:0] op);
    logic r;
    case (op) inside
      OP_PUSH, OP_PUSHC, OP_PUSHX, OP_POP, OP_POPX, OP_BNE, OP_BEQ, OP_BR, OP_CALL,
      OP_RETURN, OP_ADDX, OP_ADDSP: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] alu(input logic [5:0] op, input logic [31:0] a,
                                      input logic [31:0] b);
    logic [31:0] r;
    case (op)
      OP_ADD:  r = a + b;
      OP_SUB:  r = a - b;
      OP_MUL:  r = a * b;
      OP_OR:   r = {31'd0, (a != 32'd0) || (b != 32'd0)};
      OP_AND:  r = {31'd0, (a != 32'd0) && (b != 32'd0)};
      default: r = {31'd0, (a != 32'd0) != (b != 32'd0)};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/stk_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module stk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

### hdl/stk_div.sv
// Iterative signed 32-bit divider giving truncated quotient and remainder.
`default_nettype none
module stk_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             done_o,
  output logic [31:0]      quot_o,
  output logic [31:0]      rem_o
);
  logic        busy_q, busy_d, done_q, done_d, negq_q, negq_d, negr_q, negr_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] r_q, r_d, q_q, q_d, d_q, d_d;
  logic [32:0] shifted;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    r_d     = r_q;
    q_d     = q_q;
    d_d     = d_q;
    negq_d  = negq_q;
    negr_d  = negr_q;
    shifted = {r_q, q_q[31]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'd0;
      r_d    = 32'd0;
      q_d    = dividend_i[31] ? (32'd0 - dividend_i) : dividend_i;
      d_d    = divisor_i[31] ? (32'd0 - divisor_i) : divisor_i;
      negq_d = dividend_i[31] ^ divisor_i[31];
      negr_d = dividend_i[31];
    end else if (busy_q) begin
      if (shifted >= {1'b0, d_q}) begin
        r_d = 32'(shifted - {1'b0, d_q});
        q_d = {q_q[30:0], 1'b1};
      end else begin
        r_d = shifted[31:0];
        q_d = {q_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q    <= r_d;
    q_q    <= q_d;
    d_q    <= d_d;
    negq_q <= negq_d;
    negr_q <= negr_d;
  end

  assign done_o = done_q;
  assign quot_o = negq_q ? (32'd0 - q_q) : q_q;
  assign rem_o  = negr_q ? (32'd0 - r_q) : r_q;
endmodule
`default_nettype wire

### hdl/stack_machine_execute_unit.sv
// Top level of the stack machine execute unit: sequencer around the main memory.
// A write or pc transaction goes straight to its response; an executed
// instruction fetches its opcode (and its operand, if it has one), then runs
// its memory steps, and divide or modulo also waits for the iterative divider.
// One transaction is worked on at a time; each memory step is at most one RAM access.
// After reset a clearing pass zeroes every memory word before the first input.
`default_nettype none
module stack_machine_execute_unit #(
  parameter int MEM_WORDS = 16384
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // address[13:0], data[45:14], read_value[77:46], read_eof[78], read_bad[79]
  input  wire logic [79:0]  s_axis_tdata_i,
  // mode[1:0]
  input  wire logic [1:0]   s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // out_value[31:0], error_code[35:32], read_used[36], pc_now[68:37],
  // stack_top_index[100:69], trace_flag[101], zero[103:102]
  output logic [103:0]      m_axis_tdata_o,
  // status[2:0]
  output logic [2:0]        m_axis_tuser_o
);
  import stk_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_FETCH = 8'b00000100,
    S_OPC   = 8'b00001000,
    S_ARG   = 8'b00010000,
    S_EXEC  = 8'b00100000,
    S_DIV   = 8'b01000000,
    S_RESP  = 8'b10000000
  } state_e;

  function automatic logic in_mem(input logic [31:0] x);
    return x < 32'(MEM_WORDS);
  endfunction

  state_e      state_q, state_d;
  logic [31:0] pc_q, pc_d, sp_q, sp_d;
  logic        halt_q, halt_d, fault_q, fault_d, eofs_q, eofs_d, trace_q, trace_d;
  logic [3:0]  fcode_q, fcode_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [5:0]  op_q, op_d;
  logic [31:0] opnd_q, opnd_d, a_q, a_d, c_q, c_d;
  logic [2:0]  step_q, step_d;
  logic [31:0] rv_q, rv_d;
  logic        eof_q, eof_d, bad_q, bad_d, rzero_q, rzero_d;
  logic [2:0]  stat_q, stat_d;
  logic [3:0]  code_q, code_d;
  logic [31:0] outv_q, outv_d;
  logic        used_q, used_d;
  logic        ovalid_q, ovalid_d;
  logic [103:0] otdata_q, otdata_d;
  logic [2:0]  otuser_q, otuser_d;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_wa, ram_ra;
  logic [31:0]   ram_wd, ram_q, rd_data;
  logic          div_start, div_done;
  logic [31:0]   div_quot, div_rem;

  logic        pop_done, pop_req, push_req, wr_req, rd_req, sp_add, finish;
  logic [31:0] push_v, wr_a, wr_v, rd_a, spn, s_new;
  logic [3:0]  err;
  logic        s_acc;

  stk_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_mem (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_wa),
    .wdata_i (ram_wd),
    .re_i    (ram_re),
    .raddr_i (ram_ra),
    .rdata_o (ram_q)
  );

  stk_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (a_d),
    .divisor_i  (c_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign rd_data = rzero_q ? sp_q : ram_q;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d = state_q;  pc_d = pc_q;  sp_d = sp_q;  halt_d = halt_q;
    fault_d = fault_q;  eofs_d = eofs_q;  trace_d = trace_q;  fcode_d = fcode_q;
    clr_d = clr_q;  op_d = op_q;  opnd_d = opnd_q;  a_d = a_q;  c_d = c_q;
    step_d = step_q;  rv_d = rv_q;  eof_d = eof_q;  bad_d = bad_q;  rzero_d = rzero_q;
    stat_d = stat_q;  code_d = code_q;  outv_d = outv_q;  used_d = used_q;
    ovalid_d = ovalid_q && !m_axis_tready_i;
    otdata_d = otdata_q;  otuser_d = otuser_q;
    ram_we = 1'b0;  ram_re = 1'b0;  ram_wa = '0;  ram_ra = '0;  ram_wd = 32'd0;
    div_start = 1'b0;
    pop_done = 1'b0;  pop_req = 1'b0;  push_req = 1'b0;  wr_req = 1'b0;
    rd_req = 1'b0;  sp_add = 1'b0;  finish = 1'b0;
    push_v = 32'd0;  wr_a = 32'd0;  wr_v = 32'd0;  rd_a = 32'd0;
    err = ERR_NONE;
    s_new = 32'd0;

    unique case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_wa = clr_q;
        clr_d  = clr_q + AW'(1);
        if (clr_q == AW'(MEM_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_acc) begin
          rv_d   = s_axis_tdata_i[77:46];
          eof_d  = s_axis_tdata_i[78];
          bad_d  = s_axis_tdata_i[79];
          stat_d = ST_DONE;  code_d = ERR_NONE;  outv_d = 32'd0;  used_d = 1'b0;
          state_d = S_RESP;
          case (s_axis_tuser_i)
            MODE_WRITE: begin
              if (in_mem({18'd0, s_axis_tdata_i[13:0]})) begin
                if (s_axis_tdata_i[13:0] == 14'd0) begin
                  sp_d = s_axis_tdata_i[45:14];
                end else begin
                  ram_we = 1'b1;
                  ram_wa = AW'(s_axis_tdata_i[13:0]);
                  ram_wd = s_axis_tdata_i[45:14];
                end
              end
            end
            MODE_SETPC: begin
              pc_d = {18'd0, s_axis_tdata_i[13:0]};
              halt_d = 1'b0;  fault_d = 1'b0;  fcode_d = ERR_NONE;
            end
            MODE_EXEC: begin
              if (fault_q) begin
                stat_d = ST_ERROR;  code_d = fcode_q;
              end else if (halt_q) begin
                stat_d = ST_HALTED;
              end else begin
                state_d = S_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      S_FETCH: begin
        if (!in_mem(pc_q)) begin
          err = ERR_PC;
        end else begin
          ram_re = 1'b1;  ram_ra = AW'(pc_q);  rzero_d = (pc_q == 32'd0);
          state_d = S_OPC;
        end
      end
      S_OPC: begin
        if (rd_data >= 32'(OPCODE_COUNT)) begin
          err = ERR_OPC;
        end else begin
          op_d = rd_data[5:0];
          pc_d = pc_q + 32'd1;
          step_d = 3'd0;
          if (has_arg(rd_data[5:0])) begin
            if (!in_mem(pc_q + 32'd1)) begin
              err = ERR_PC;
            end else begin
              ram_re = 1'b1;  ram_ra = AW'(pc_q + 32'd1);
              rzero_d = ((pc_q + 32'd1) == 32'd0);
              state_d = S_ARG;
            end
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_ARG: begin
        opnd_d = rd_data;
        pc_d = pc_q + 32'd1;
        state_d = S_EXEC;
      end
      S_DIV: begin
        if (div_done) begin
          c_d = (op_q == OP_DIV) ? div_quot : div_rem;
          step_d = 3'd3;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op_q)
          OP_BKPT: begin stat_d = ST_BKPT; finish = 1'b1; end
          OP_PUSH, OP_DUP, OP_OVER: begin
            if (step_q == 3'd0) begin
              rd_req = 1'b1;
              rd_a = (op_q == OP_PUSH) ? opnd_q :
                     (op_q == OP_DUP) ? sp_q : sp_q + 32'd1;
            end else begin
              push_req = 1'b1;  push_v = rd_data;  finish = 1'b1;
            end
          end
          OP_PUSHC: begin push_req = 1'b1; push_v = opnd_q; finish = 1'b1; end
          OP_PUSHI, OP_PUSHX: begin
            if (step_q == 3'd0) begin
              pop_req = 1'b1;
            end else if (step_q == 3'd1) begin
              pop_done = 1'b1;  rd_req = 1'b1;
              rd_a = (op_q == OP_PUSHX) ? rd_data + opnd_q : rd_data;
            end else begin
              push_req = 1'b1;  push_v = rd_data;  finish = 1'b1;
            end
          end
          OP_POP: begin
            if (step_q == 3'd0) begin
              pop_req = 1'b1;
            end else begin
              pop_done = 1'b1;  wr_req = 1'b1;  wr_a = opnd_q;  wr_v = rd_data;
              finish = 1'b1;
            end
          end
          OP_POPI, OP_POPX: begin
            if (step_q == 3'd0) begin
              pop_req = 1'b1;
            end else if (step_q == 3'd1) begin
              pop_done = 1'b1;  a_d = rd_data;  pop_req = 1'b1;
            end else begin
              pop_done = 1'b1;  wr_req = 1'b1;  wr_v = a_q;
              wr_a = (op_q == OP_POPX) ? rd_data + opnd_q : rd_data;
              finish = 1'b1;
            end
          end
          OP_SWAP: begin
            case (step_q)
              3'd0: begin c_d = sp_q; rd_req = 1'b1; rd_a = sp_q; end
              3'd1: begin a_d = rd_data; rd_req = 1'b1; rd_a = c_q + 32'd1; end
              3'd2: begin wr_req = 1'b1; wr_a = c_q; wr_v = rd_data; end
              default: begin
                wr_req = 1'b1;  wr_a = c_q + 32'd1;  wr_v = a_q;  finish = 1'b1;
              end
            endcase
          end
          OP_DROP: begin
            if (!in_mem(sp_q)) begin
              err = ERR_SP;
            end else begin
              pop_done = 1'b1;
            end
            finish = 1'b1;
          end
          OP_ROT: begin
            case (step_q)
              3'd0: begin rd_req = 1'b1; rd_a = sp_q; end
              3'd1: begin a_d = rd_data; rd_req = 1'b1; rd_a = sp_q + 32'd2; end
              3'd2: begin wr_req = 1'b1; wr_a = sp_q; wr_v = rd_data; end
              3'd3: begin rd_req = 1'b1; rd_a = sp_q + 32'd1; end
              3'd4: begin wr_req = 1'b1; wr_a = sp_q + 32'd2; wr_v = rd_data; end
              default: begin
                wr_req = 1'b1;  wr_a = sp_q + 32'd1;  wr_v = a_q;  finish = 1'b1;
              end
            endcase
          end
          OP_TSTLT, OP_TSTLE, OP_TSTGT, OP_TSTGE, OP_TSTEQ, OP_TSTNE, OP_NOT, OP_NEG: begin
            if (step_q == 3'd0) begin
              pop_req = 1'b1;
            end else begin
              pop_done = 1'b1;  push_req = 1'b1;  finish = 1'b1;
              case (op_q)
                OP_TSTLT: push_v = {31'd0, rd_data[31]};
                OP_TSTLE: push_v = {31'd0, rd_data[31] || (rd_data == 32'd0)};
                OP_TSTGT: push_v = {31'd0, !rd_data[31] && (rd_data != 32'd0)};
                OP_TSTGE: push_v = {31'd0, !rd_data[31]};
                OP_TSTNE: push_v = {31'd0, rd_data != 32'd0};
                OP_NEG:   push_v = 32'd0 - rd_data;
                default:  push_v = {31'd0, rd_data == 32'd0};
              endcase
            end
          end
          OP_BNE, OP_BEQ, OP_CALLS, OP_RETURN, OP_PRINT, OP_PRINTC: begin
            if (step_q == 3'd0) begin
              pop_req = 1'b1;
            end else begin
              pop_done = 1'b1;  finish = 1'b1;
              case (op_q)
                OP_BNE: if (rd_data != 32'd0) pc_d = opnd_q;
                OP_BEQ: if (rd_data == 32'd0) pc_d = opnd_q;
                OP_CALLS: pc_d = rd_data;
                OP_RETURN: begin pc_d = rd_data; sp_add = 1'b1; end
                OP_PRINT: begin outv_d = rd_data; stat_d = ST_PRINT; end
                default: begin outv_d = rd_data; stat_d = ST_PRINTC; end
              endcase
            end
          end
          OP_BR: begin pc_d = opnd_q; finish = 1'b1; end
          OP_CALL: begin
            push_req = 1'b1;  push_v = pc_q;  pc_d = opnd_q;  finish = 1'b1;
          end
          OP_HALT: begin halt_d = 1'b1; stat_d = ST_HALTED; finish = 1'b1; end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_OR, OP_AND, OP_XOR: begin
            case (step_q)
              3'd0: pop_req = 1'b1;
              3'd1: begin
                pop_done = 1'b1;  c_d = rd_data;
                if ((op_q == OP_DIV || op_q == OP_MOD) && rd_data == 32'd0) begin
                  err = ERR_DIV0;
                end else begin
                  pop_req = 1'b1;
                end
              end
              3'd2: begin
                pop_done = 1'b1;  a_d = rd_data;
                if (op_q == OP_DIV || op_q == OP_MOD) begin
                  state_d = S_DIV;
                end else begin
                  push_req = 1'b1;  push_v = alu(op_q, rd_data, c_q);  finish = 1'b1;
                end
              end
              default: begin push_req = 1'b1; push_v = c_q; finish = 1'b1; end
            endcase
          end
          OP_ADDX: begin
            case (step_q)
              3'd0: pop_req = 1'b1;
              3'd1: begin pop_done = 1'b1; a_d = rd_data; rd_req = 1'b1; rd_a = opnd_q; end
              default: begin
                wr_req = 1'b1;  wr_a = opnd_q;  wr_v = rd_data + a_q;  finish = 1'b1;
              end
            endcase
          end
          OP_ADDSP: begin sp_add = 1'b1; finish = 1'b1; end
          OP_READ: begin
            finish = 1'b1;
            if (eofs_q) begin
              err = ERR_EOF;
            end else begin
              used_d = 1'b1;
              if (eof_q) begin
                eofs_d = 1'b1;  err = ERR_EOF;
              end else if (bad_q) begin
                err = ERR_BADINT;
              end else begin
                push_req = 1'b1;  push_v = rv_q;
              end
            end
          end
          OP_READC: begin
            finish = 1'b1;  push_req = 1'b1;  push_v = 32'hFFFF_FFFF;
            if (!eofs_q) begin
              used_d = 1'b1;
              if (eof_q) begin
                eofs_d = 1'b1;
              end else begin
                push_v = {24'd0, rv_q[7:0]};
              end
            end
          end
          OP_TRON: begin trace_d = 1'b1; finish = 1'b1; end
          OP_TROFF: begin trace_d = 1'b0; finish = 1'b1; end
          default: begin
            case (step_q)
              3'd0: pop_req = 1'b1;
              3'd1: begin pop_done = 1'b1; a_d = rd_data; pop_req = 1'b1; end
              default: begin
                pop_done = 1'b1;  finish = 1'b1;
                if (!in_mem(a_q) || !in_mem(rd_data) ||
                    ($signed(rd_data) > $signed(a_q))) begin
                  err = ERR_DUMP;
                end
              end
            endcase
          end
        endcase
        step_d = step_q + 3'd1;
      end
      S_RESP: begin
        if (!ovalid_q || m_axis_tready_i) begin
          ovalid_d = 1'b1;
          otuser_d = stat_q;
          otdata_d = {2'd0, trace_q, sp_q, pc_q, used_q, code_q, outv_q};
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    spn = pop_done ? sp_q + 32'd1 : sp_q;
    if (state_q == S_EXEC) begin
      sp_d = sp_add ? spn + opnd_q : spn;
      if (push_req) begin
        s_new = spn - 32'd1;
        sp_d = s_new;
        if (!in_mem(s_new)) begin
          err = ERR_SP;
        end else if (s_new == 32'd0) begin
          sp_d = push_v;
        end else begin
          ram_we = 1'b1;  ram_wa = AW'(s_new);  ram_wd = push_v;
        end
      end
      if (wr_req) begin
        if (!in_mem(wr_a)) begin
          err = ERR_ADDR;
        end else if (wr_a == 32'd0) begin
          sp_d = wr_v;
        end else begin
          ram_we = 1'b1;  ram_wa = AW'(wr_a);  ram_wd = wr_v;
        end
      end
      if (rd_req) begin
        if (!in_mem(rd_a)) begin
          err = ERR_ADDR;
        end else begin
          ram_re = 1'b1;  ram_ra = AW'(rd_a);  rzero_d = (rd_a == 32'd0);
        end
      end
      if (pop_req && err == ERR_NONE) begin
        if (!in_mem(spn)) begin
          err = ERR_SP;
        end else begin
          ram_re = 1'b1;  ram_ra = AW'(spn);  rzero_d = (spn == 32'd0);
        end
      end
      if (state_d == S_DIV) begin
        div_start = 1'b1;
      end
    end
    if (err != ERR_NONE) begin
      if (state_q == S_EXEC) begin
        pc_d = pc_q;
      end
      fault_d = 1'b1;  fcode_d = err;
      stat_d = ST_ERROR;  code_d = err;  outv_d = 32'd0;
      state_d = S_RESP;
    end else if (finish) begin
      state_d = S_RESP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      pc_q     <= 32'd0;
      sp_q     <= 32'(MEM_WORDS);
      halt_q   <= 1'b0;
      fault_q  <= 1'b0;
      eofs_q   <= 1'b0;
      trace_q  <= 1'b0;
      fcode_q  <= ERR_NONE;
      clr_q    <= '0;
      step_q   <= 3'd0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pc_q     <= pc_d;
      sp_q     <= sp_d;
      halt_q   <= halt_d;
      fault_q  <= fault_d;
      eofs_q   <= eofs_d;
      trace_q  <= trace_d;
      fcode_q  <= fcode_d;
      clr_q    <= clr_d;
      step_q   <= step_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    opnd_q   <= opnd_d;
    a_q      <= a_d;
    c_q      <= c_d;
    rv_q     <= rv_d;
    eof_q    <= eof_d;
    bad_q    <= bad_d;
    rzero_q  <= rzero_d;
    stat_q   <= stat_d;
    code_q   <= code_d;
    outv_q   <= outv_d;
    used_q   <= used_d;
    otdata_q <= otdata_d;
    otuser_q <= otuser_d;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = otdata_q;
  assign m_axis_tuser_o  = otuser_q;

  a_rise_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(state_q == S_RESP))
    else $error("result valid without a response step");
  a_err_has_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && otuser_q == ST_ERROR) |-> (otdata_q[35:32] != ERR_NONE))
    else $error("error status without error code");
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !s_axis_tready_o)
    else $error("input taken during clearing pass");
  a_idle_sp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !s_acc) |=> $stable(sp_q))
    else $error("stack pointer moved while idle");
endmodule
`default_nettype wire

### dv/tb_stack_machine_execute_unit.sv
// Self-checking testbench for the stack machine execute unit with a built-in scoreboard.
`default_nettype none
module tb_stack_machine_execute_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import stk_pkg::*;

  localparam int MEM_WORDS = 16384;
  localparam int STALL_LIMIT = 60000;
  localparam int ITEM_TARGET = 1950;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_value;
    logic [3:0]  error_code;
    logic        read_used;
    logic [31:0] pc_now;
    logic [31:0] stack_top;
    logic        trace_flag;
  } step_result_t;

  class exec_scoreboard;
    logic [31:0]  mem [MEM_WORDS];
    logic [31:0]  pc;
    bit           halted, stopped, eof_seen, trace_on;
    logic [3:0]   stop_code, err;
    step_result_t pending[$];
    int           mismatches;

    function new();
      foreach (mem[i]) mem[i] = '0;
      mem[0] = MEM_WORDS;
      pc = '0;
      halted = 0;
      stopped = 0;
      eof_seen = 0;
      trace_on = 0;
      stop_code = ERR_NONE;
      mismatches = 0;
    endfunction

    function bit in_range(logic [31:0] a);
      return a < MEM_WORDS;
    endfunction

    function bit load(logic [31:0] a, output logic [31:0] v);
      v = '0;
      if (!in_range(a)) begin
        err = ERR_ADDR;
        return 0;
      end
      v = mem[a];
      return 1;
    endfunction

    function bit store(logic [31:0] a, logic [31:0] v);
      if (!in_range(a)) begin
        err = ERR_ADDR;
        return 0;
      end
      mem[a] = v;
      return 1;
    endfunction

    function bit push(logic [31:0] v);
      logic [31:0] s;
      s = mem[0] - 1;
      mem[0] = s;
      if (!in_range(s)) begin
        err = ERR_SP;
        return 0;
      end
      mem[s] = v;
      return 1;
    endfunction

    function bit pop(output logic [31:0] v);
      logic [31:0] s;
      s = mem[0];
      v = '0;
      if (!in_range(s)) begin
        err = ERR_SP;
        return 0;
      end
      v = mem[s];
      mem[0] = s + 1;
      return 1;
    endfunction

    function bit takes_operand(logic [5:0] op);
      case (op)
        OP_PUSH, OP_PUSHC, OP_PUSHX, OP_POP, OP_POPX, OP_BNE, OP_BEQ, OP_BR, OP_CALL,
        OP_RETURN, OP_ADDX, OP_ADDSP: return 1;
        default: return 0;
      endcase
    endfunction

    function logic [31:0] arith(logic [5:0] op, logic [31:0] a, logic [31:0] b);
      bit                 ovf;
      logic signed [31:0] sa, sb, sq;
      ovf = (a == 32'h8000_0000) && (b == 32'hFFFF_FFFF);
      sa = a;
      sb = b;
      case (op)
        OP_ADD: return a + b;
        OP_SUB: return a - b;
        OP_MUL: return a * b;
        OP_DIV: begin
          if (ovf) return 32'h8000_0000;
          sq = sa / sb;
          return sq;
        end
        OP_MOD: begin
          if (ovf) return 32'h0;
          sq = sa % sb;
          return sq;
        end
        OP_OR:  return {31'd0, (a != 0) || (b != 0)};
        OP_AND: return {31'd0, (a != 0) && (b != 0)};
        default: return {31'd0, (a != 0) != (b != 0)};
      endcase
    endfunction

    function logic [2:0] execute(logic [31:0] rv, bit eof, bit bad,
                                 output logic [31:0] outv, output bit used);
      logic [31:0] word, opnd, a, b, c, s;
      logic [5:0]  op;
      logic [2:0]  st;
      outv = '0;
      used = 0;
      st = ST_DONE;
      opnd = '0;
      if (!in_range(pc)) begin
        err = ERR_PC;
        return st;
      end
      word = mem[pc];
      if (word >= OPCODE_COUNT) begin
        err = ERR_OPC;
        return st;
      end
      op = word[5:0];
      pc = pc + 1;
      if (takes_operand(op)) begin
        if (!in_range(pc)) begin
          err = ERR_PC;
          return st;
        end
        opnd = mem[pc];
        pc = pc + 1;
      end
      case (op)
        OP_BKPT:  st = ST_BKPT;
        OP_PUSH:  if (load(opnd, a)) void'(push(a));
        OP_PUSHC: void'(push(opnd));
        OP_PUSHI: if (pop(a) && load(a, b)) void'(push(b));
        OP_PUSHX: if (pop(a) && load(a + opnd, b)) void'(push(b));
        OP_POP:   if (pop(a)) void'(store(opnd, a));
        OP_POPI:  if (pop(a) && pop(b)) void'(store(b, a));
        OP_POPX:  if (pop(a) && pop(b)) void'(store(b + opnd, a));
        OP_DUP:   if (load(mem[0], a)) void'(push(a));
        OP_SWAP: begin
          s = mem[0];
          if (load(s, a) && load(s + 1, b) && store(s, b)) void'(store(s + 1, a));
        end
        OP_OVER:  if (load(mem[0] + 1, a)) void'(push(a));
        OP_DROP: begin
          if (!in_range(mem[0])) err = ERR_SP;
          else mem[0] = mem[0] + 1;
        end
        OP_ROT: begin
          if (load(mem[0], a) && load(mem[0] + 2, b) && store(mem[0], b) &&
              load(mem[0] + 1, c) && store(mem[0] + 2, c))
            void'(store(mem[0] + 1, a));
        end
        OP_TSTLT: if (pop(a)) void'(push({31'd0, a[31]}));
        OP_TSTLE: if (pop(a)) void'(push({31'd0, a[31] || a == 0}));
        OP_TSTGT: if (pop(a)) void'(push({31'd0, !a[31] && a != 0}));
        OP_TSTGE: if (pop(a)) void'(push({31'd0, !a[31]}));
        OP_TSTEQ, OP_NOT: if (pop(a)) void'(push({31'd0, a == 0}));
        OP_TSTNE: if (pop(a)) void'(push({31'd0, a != 0}));
        OP_BNE:   if (pop(a) && a != 0) pc = opnd;
        OP_BEQ:   if (pop(a) && a == 0) pc = opnd;
        OP_BR:    pc = opnd;
        OP_CALL:  if (push(pc)) pc = opnd;
        OP_CALLS: if (pop(a)) pc = a;
        OP_RETURN: begin
          if (pop(a)) begin
            pc = a;
            mem[0] = mem[0] + opnd;
          end
        end
        OP_HALT: begin
          halted = 1;
          st = ST_HALTED;
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_OR, OP_AND, OP_XOR: begin
          if (pop(b)) begin
            if ((op == OP_DIV || op == OP_MOD) && b == 0) err = ERR_DIV0;
            else if (pop(a)) void'(push(arith(op, a, b)));
          end
        end
        OP_NEG:   if (pop(a)) void'(push(32'd0 - a));
        OP_ADDX:  if (pop(a) && load(opnd, b)) void'(store(opnd, b + a));
        OP_ADDSP: mem[0] = mem[0] + opnd;
        OP_READ: begin
          if (eof_seen) err = ERR_EOF;
          else begin
            used = 1;
            if (eof) begin
              eof_seen = 1;
              err = ERR_EOF;
            end else if (bad) err = ERR_BADINT;
            else void'(push(rv));
          end
        end
        OP_PRINT: if (pop(a)) begin
          outv = a;
          st = ST_PRINT;
        end
        OP_READC: begin
          if (eof_seen) void'(push(32'hFFFF_FFFF));
          else begin
            used = 1;
            if (eof) begin
              eof_seen = 1;
              void'(push(32'hFFFF_FFFF));
            end else void'(push({24'd0, rv[7:0]}));
          end
        end
        OP_PRINTC: if (pop(a)) begin
          outv = a;
          st = ST_PRINTC;
        end
        OP_TRON:  trace_on = 1;
        OP_TROFF: trace_on = 0;
        default: begin
          if (pop(a) && pop(b)) begin
            if (!in_range(a) || !in_range(b) || $signed(b) > $signed(a)) err = ERR_DUMP;
          end
        end
      endcase
      return st;
    endfunction

    function void note_transaction(logic [1:0] mode, logic [13:0] addr, logic [31:0] data,
                                   logic [31:0] rv, bit eof, bit bad);
      step_result_t r;
      logic [31:0]  outv;
      bit           used;
      r = '0;
      case (mode)
        MODE_WRITE: if (in_range({18'd0, addr})) mem[addr] = data;
        MODE_SETPC: begin
          pc = {18'd0, addr};
          halted = 0;
          stopped = 0;
          stop_code = ERR_NONE;
        end
        MODE_EXEC: begin
          if (stopped) begin
            r.status = ST_ERROR;
            r.error_code = stop_code;
          end else if (halted) r.status = ST_HALTED;
          else begin
            err = ERR_NONE;
            r.status = execute(rv, eof, bad, outv, used);
            r.out_value = outv;
            r.read_used = used;
            if (err != ERR_NONE) begin
              stopped = 1;
              stop_code = err;
              r.status = ST_ERROR;
              r.error_code = err;
              r.out_value = '0;
            end
          end
        end
        default: ;
      endcase
      r.pc_now = pc;
      r.stack_top = mem[0];
      r.trace_flag = trace_on;
      pending.push_back(r);
    endfunction

    function void check_transaction(logic [103:0] d, logic [2:0] u);
      step_result_t got, want;
      got = {u, d[31:0], d[35:32], d[36], d[68:37], d[100:69], d[101]};
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction: %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.out_value !== want.out_value ||
          got.error_code !== want.error_code || got.read_used !== want.read_used ||
          got.pc_now !== want.pc_now || got.stack_top !== want.stack_top ||
          got.trace_flag !== want.trace_flag) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch at %0t", $realtime);
          $display("  expected %p", want);
          $display("  actual   %p", got);
        end
      end
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready_o;
  logic [79:0]   s_axis_tdata = '0;
  logic [1:0]    s_axis_tuser = '0;
  logic          m_axis_tvalid_o;
  logic          m_axis_tready = 1'b0;
  logic [103:0]  m_axis_tdata_o;
  logic [2:0]    m_axis_tuser_o;

  exec_scoreboard sb = new();
  int  items_sent = 0;
  int  idle_cycles = 0;
  bit  src_burst = 0;

  always #10 clk_i = ~clk_i;

  stack_machine_execute_unit #(.MEM_WORDS(MEM_WORDS)) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  task automatic send_item(input logic [1:0] mode, input logic [13:0] addr,
                           input logic [31:0] data, input logic [31:0] rv = '0,
                           input bit eof = 0, input bit bad = 0);
    int gap;
    if ($urandom_range(0, 31) == 0) src_burst = !src_burst;
    gap = src_burst ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {bad, eof, rv, data, addr};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_transaction(mode, addr, data, rv, eof, bad);
    items_sent++;
  endtask

  function automatic logic [31:0] pick_value(logic [31:0] sp0);
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return $urandom_range(1, 16);
      2: return sp0 + $urandom_range(0, 16) - 8;
      3: return 32'hFFFF_FFFF;
      4: return 32'h8000_0000;
      5: return 32'h7FFF_FFFF;
      6: return $urandom_range(0, MEM_WORDS - 1);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_program(input int len, input bit eof_allowed);
    logic [31:0] base, sp0, word, opnd;
    int          depth, k;
    base = $urandom_range(64, 6000);
    case ($urandom_range(0, 9))
      0: sp0 = MEM_WORDS;
      1: sp0 = $urandom_range(0, 3);
      2: sp0 = $urandom;
      default: sp0 = $urandom_range(7000, MEM_WORDS - 1);
    endcase
    send_item(MODE_WRITE, '0, sp0);
    depth = $urandom_range(0, 6);
    for (int i = 0; i < depth; i++)
      if (sp0 + i < MEM_WORDS && sp0 + i > 0)
        send_item(MODE_WRITE, 14'(sp0 + i), pick_value(sp0));
    k = 0;
    for (int i = 0; i < len; i++) begin
      word = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, OPCODE_COUNT - 1);
      send_item(MODE_WRITE, 14'(base + k), word);
      k++;
      if (word < OPCODE_COUNT && sb.takes_operand(word[5:0])) begin
        case (word[5:0])
          OP_BNE, OP_BEQ, OP_BR, OP_CALL: opnd = base + $urandom_range(0, 2 * len);
          OP_RETURN, OP_ADDSP: opnd = $urandom_range(0, 8) - 4;
          default: opnd = pick_value(sp0);
        endcase
        send_item(MODE_WRITE, 14'(base + k), opnd);
        k++;
      end
    end
    send_item(MODE_SETPC, 14'(base), $urandom);
    repeat (len + 3)
      send_item(MODE_EXEC, 14'($urandom), $urandom, $urandom,
                eof_allowed && $urandom_range(0, 40) == 0, $urandom_range(0, 7) == 0);
  endtask

  initial begin
    logic [31:0] prog[$];
    prog = '{OP_PUSHC, 32'h8000_0000, OP_PUSHC, 32'hFFFF_FFFF, OP_DIV, OP_PRINT,
             OP_READ, OP_READC, OP_PRINTC, OP_BKPT, OP_HALT};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (prog[i]) send_item(MODE_WRITE, 14'(i + 1), prog[i]);
    send_item(MODE_SETPC, 14'd1, '0);
    repeat (3) send_item(MODE_EXEC, '1, '1, '0);
    send_item(MODE_EXEC, '0, '0, 32'h7FFF_FFFF);
    send_item(MODE_EXEC, '0, '0, 32'hFFFF_FF41);
    repeat (4) send_item(MODE_EXEC, '0, '0, '0);
    send_item(MODE_WRITE, 14'h3FFF, {26'd0, OP_PUSH});
    send_item(MODE_SETPC, 14'h3FFF, '0);
    send_item(MODE_EXEC, '0, '0, '0, 1'b0, 1'b1);
    send_item(MODE_EXEC, '0, '0, '0);
    send_item(2'd3, 14'h3FFF, '1, '1, 1'b1, 1'b1);

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0)
        send_item(2'($urandom_range(0, 3)), 14'($urandom), $urandom, $urandom,
                  $urandom_range(0, 1), $urandom_range(0, 1));
      else
        run_program($urandom_range(4, 16), items_sent > ITEM_TARGET * 3 / 4);
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    int  stall;
    bit  sink_burst;
    sink_burst = 0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 31) == 0) sink_burst = !sink_burst;
      stall = sink_burst ? 0 : $urandom_range(0, 16);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready) sb.check_transaction(m_axis_tdata_o, m_axis_tuser_o);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
`default_nettype wire

### stack_machine_execute_unit.f
hdl/stk_pkg.sv
hdl/stk_ram.sv
hdl/stk_div.sv
hdl/stack_machine_execute_unit.sv
dv/tb_stack_machine_execute_unit.sv
